// ===== rtl/vidm_pkg.sv =====
// ----------------------------------------------------------------------------
// vidm_pkg
// Shared types and constants for the vendor ID payload matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package vidm_pkg;

	// Table geometry; PATTERN_BYTES must stay a power of two
	localparam int TABLE_ENTRIES = 128;
	localparam int PATTERN_BYTES = 16;
	localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
	localparam int POS_W         = $clog2(PATTERN_BYTES);
	localparam int PAT_AW        = ENTRY_W + POS_W;
	localparam int CNT_W         = $clog2(PATTERN_BYTES + 2);
	localparam int LEN_W         = 5;

	// Input opcodes
	typedef enum logic [1:0] {
		OP_LOAD_PATTERN = 2'd0,
		OP_LOAD_DESC    = 2'd1,
		OP_PAYLOAD      = 2'd2,
		OP_NEW_MESSAGE  = 2'd3
	} opcode_t;

	// Entry actions
	typedef enum logic [2:0] {
		ACT_NONE        = 3'd0,
		ACT_USEFUL      = 3'd1,
		ACT_OPENPGP     = 3'd2,
		ACT_NT5         = 3'd3,
		ACT_NATT_LEGACY = 3'd4,
		ACT_NATT_FLOAT  = 3'd5,
		ACT_DPD         = 3'd6
	} action_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_NATT_ENABLED    = 2'd0,
		CFG_NATT_NON_IKE    = 2'd1,
		CFG_NATT_PORT_FLOAT = 2'd2
	} cfg_reg_t;

	// Entry descriptor as stored
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             prefix;
		logic [2:0]       action;
		logic [3:0]       rank;
	} desc_t;

	// Input item, tdata part, first field highest
	typedef struct packed {
		logic [3:0]       natt_rank_in;
		logic [2:0]       action_code;
		logic             prefix_allowed;
		logic [LEN_W-1:0] pattern_length;
		logic [7:0]       data_byte;
		logic [3:0]       byte_position;
		logic [6:0]       entry_index;
	} in_item_t;

	// Result item, first field highest
	typedef struct packed {
		logic [3:0] natt_rank_chosen;
		logic       peer_dpd;
		logic       peer_ms_nt5;
		logic       peer_openpgp;
		logic       useful;
		logic [6:0] match_entry;
		logic       matched;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/vendor_id_payload_matcher_top.sv =====
// ----------------------------------------------------------------------------
// vendor_id_payload_matcher_top
// Matches vendor ID payloads byte by byte against a loaded pattern table.
// ----------------------------------------------------------------------------
// A load or new-message item is taken in the idle state. A payload byte sweeps
// the table one entry per cycle through the pattern, descriptor and alive
// memories; a last byte stops at the first match and then holds its result in
// the result state while the output stalls.
// Throughput: one item at a time. Reset clears flags, rank, count and descriptor
// valid bits; a payload's first byte treats every entry as alive, so no clearing.
`default_nettype none

module vendor_id_payload_matcher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// entry_index[6:0], byte_position[10:7], data_byte[18:11],
	// pattern_length[23:19], prefix_allowed[24], action_code[27:25],
	// natt_rank_in[31:28]
	input  wire logic [31:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// last_byte
	input  wire logic        s_axis_tlast,
	// result item
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// matched[0], match_entry[7:1], useful[8], peer_openpgp[9],
	// peer_ms_nt5[10], peer_dpd[11], natt_rank_chosen[15:12]
	output logic [15:0]      m_axis_tdata,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SWEEP  = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	localparam logic [vidm_pkg::ENTRY_W-1:0] LAST_ENTRY =
		vidm_pkg::ENTRY_W'(vidm_pkg::TABLE_ENTRIES - 1);

	state_t state_q;

	vidm_pkg::in_item_t in_item;
	vidm_pkg::opcode_t  in_op;
	logic               in_acc;

	// Configuration
	logic natt_en_q, natt_non_ike_q, natt_float_q;

	// Per-message state and descriptor valid bits
	logic                       flag_pgp_q, flag_nt5_q, flag_dpd_q;
	logic [3:0]                 rank_held_q;
	logic [vidm_pkg::CNT_W-1:0] cnt_q;
	logic [vidm_pkg::CNT_W-1:0] cnt_next;
	logic [vidm_pkg::TABLE_ENTRIES-1:0] desc_vld_q;

	// Memories
	logic [7:0]      pat_mem [vidm_pkg::TABLE_ENTRIES * vidm_pkg::PATTERN_BYTES];
	vidm_pkg::desc_t desc_mem [vidm_pkg::TABLE_ENTRIES];
	logic            alive_mem [vidm_pkg::TABLE_ENTRIES];

	// Current payload byte
	logic [7:0]                 byte_q;
	logic                       last_q;
	logic                       first_q;
	logic                       cmp_en_q;
	logic [vidm_pkg::POS_W-1:0] pos_q;
	logic [vidm_pkg::CNT_W-1:0] total_q;

	// Sweep pipeline
	logic                         issue_q;
	logic [vidm_pkg::ENTRY_W-1:0] rd_e_q;
	logic                         vld_s1;
	logic [vidm_pkg::ENTRY_W-1:0] e_s1;
	logic [7:0]                   pat_s1;
	vidm_pkg::desc_t              desc_s1;
	logic                         alive_s1;

	// Pending result
	logic                         pend_found_q;
	logic [vidm_pkg::ENTRY_W-1:0] pend_hit_q;
	vidm_pkg::desc_t              pend_desc_q;

	// Output register
	logic                out_vld_q;
	vidm_pkg::out_item_t out_q;

	assign in_item       = vidm_pkg::in_item_t'(s_axis_tdata);
	assign in_op         = vidm_pkg::opcode_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// Saturating payload count after this byte
	always_comb begin
		if (cnt_q < vidm_pkg::CNT_W'(vidm_pkg::PATTERN_BYTES + 1)) begin
			cnt_next = cnt_q + 1'b1;
		end else begin
			cnt_next = cnt_q;
		end
	end

	// Pattern memory: write on load, registered read during the sweep
	always_ff @(posedge clk) begin
		if (in_acc && in_op == vidm_pkg::OP_LOAD_PATTERN &&
		    32'(in_item.entry_index) < vidm_pkg::TABLE_ENTRIES &&
		    32'(in_item.byte_position) < vidm_pkg::PATTERN_BYTES) begin
			pat_mem[{vidm_pkg::ENTRY_W'(in_item.entry_index),
			         vidm_pkg::POS_W'(in_item.byte_position)}] <= in_item.data_byte;
		end
		pat_s1 <= pat_mem[{rd_e_q, pos_q}];
	end

	// Descriptor memory: write on load, registered read during the sweep
	always_ff @(posedge clk) begin
		if (in_acc && in_op == vidm_pkg::OP_LOAD_DESC &&
		    32'(in_item.entry_index) < vidm_pkg::TABLE_ENTRIES) begin
			desc_mem[vidm_pkg::ENTRY_W'(in_item.entry_index)] <= '{
				len:    (in_item.pattern_length >
				         vidm_pkg::LEN_W'(vidm_pkg::PATTERN_BYTES)) ?
				        vidm_pkg::LEN_W'(vidm_pkg::PATTERN_BYTES) :
				        in_item.pattern_length,
				prefix: in_item.prefix_allowed,
				action: in_item.action_code,
				rank:   in_item.natt_rank_in
			};
		end
		desc_s1 <= desc_mem[rd_e_q];
	end

	// Stage 1 evaluation of one entry
	logic [vidm_pkg::LEN_W-1:0] len_s1;
	logic                       mismatch_s1;
	logic                       alive_nx_s1;
	logic                       hit_s1;
	logic                       sweep_end;
	logic                       res_go;

	always_comb begin
		len_s1      = desc_vld_q[e_s1] ? desc_s1.len : '0;
		mismatch_s1 = cmp_en_q && (vidm_pkg::LEN_W'(pos_q) < len_s1) &&
		              (pat_s1 != byte_q);
		// the first byte of a payload starts with every entry alive
		alive_nx_s1 = (first_q || alive_s1) && !mismatch_s1;
		hit_s1      = last_q && alive_nx_s1 && (len_s1 != '0) &&
		              ((vidm_pkg::CNT_W'(len_s1) == total_q) ||
		               ((vidm_pkg::CNT_W'(len_s1) < total_q) && desc_s1.prefix));
	end

	assign sweep_end = (state_q == ST_SWEEP) && vld_s1 && (hit_s1 || e_s1 == LAST_ENTRY);
	assign res_go    = (state_q == ST_RESULT) && (!out_vld_q || m_axis_tready);

	// Alive memory: registered read ahead of evaluation, write back after evaluation; an
	// entry is read again only a full sweep later, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP && vld_s1) begin
			alive_mem[e_s1] <= alive_nx_s1;
		end
		alive_s1 <= alive_mem[rd_e_q];
	end

	// Apply the matched action
	logic       act_useful;
	logic       act_pgp, act_nt5, act_dpd;
	logic [3:0] act_rank;

	always_comb begin
		act_useful = 1'b0;
		act_pgp    = flag_pgp_q;
		act_nt5    = flag_nt5_q;
		act_dpd    = flag_dpd_q;
		act_rank   = rank_held_q;
		if (pend_found_q) begin
			case (vidm_pkg::action_t'(pend_desc_q.action))
				vidm_pkg::ACT_USEFUL: begin
					act_useful = 1'b1;
				end
				vidm_pkg::ACT_OPENPGP: begin
					act_pgp    = 1'b1;
					act_useful = 1'b1;
				end
				vidm_pkg::ACT_NT5: begin
					act_nt5    = 1'b1;
					act_useful = 1'b1;
				end
				vidm_pkg::ACT_NATT_LEGACY: begin
					if (natt_non_ike_q && natt_en_q && rank_held_q == '0) begin
						act_rank   = pend_desc_q.rank;
						act_useful = 1'b1;
					end
				end
				vidm_pkg::ACT_NATT_FLOAT: begin
					if (natt_float_q && rank_held_q < pend_desc_q.rank) begin
						act_rank   = pend_desc_q.rank;
						act_useful = 1'b1;
					end
				end
				vidm_pkg::ACT_DPD: begin
					act_dpd    = 1'b1;
					act_useful = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			natt_en_q      <= 1'b0;
			natt_non_ike_q <= 1'b0;
			natt_float_q   <= 1'b0;
		end else if (cfg_we) begin
			case (vidm_pkg::cfg_reg_t'(cfg_index))
				vidm_pkg::CFG_NATT_ENABLED:    natt_en_q      <= cfg_wdata;
				vidm_pkg::CFG_NATT_NON_IKE:    natt_non_ike_q <= cfg_wdata;
				vidm_pkg::CFG_NATT_PORT_FLOAT: natt_float_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Payload byte registers
	always_ff @(posedge clk) begin
		if (in_acc && in_op == vidm_pkg::OP_PAYLOAD) begin
			byte_q   <= in_item.data_byte;
			last_q   <= s_axis_tlast;
			first_q  <= (cnt_q == '0);
			cmp_en_q <= cnt_q < vidm_pkg::CNT_W'(vidm_pkg::PATTERN_BYTES);
			pos_q    <= vidm_pkg::POS_W'(cnt_q);
			total_q  <= cnt_next;
		end
		if (state_q == ST_SWEEP && vld_s1) begin
			pend_hit_q  <= e_s1;
			pend_desc_q <= desc_s1;
		end
		e_s1 <= rd_e_q;
	end

	// Control: sequencer, sweep, per-message state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= 1'b0;
			rd_e_q       <= '0;
			vld_s1       <= 1'b0;
			pend_found_q <= 1'b0;
			flag_pgp_q   <= 1'b0;
			flag_nt5_q   <= 1'b0;
			flag_dpd_q   <= 1'b0;
			rank_held_q  <= '0;
			cnt_q        <= '0;
			desc_vld_q   <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			// load a new result, or drop the current one once taken
			if (res_go) begin
				out_vld_q <= 1'b1;
				out_q     <= '{
					natt_rank_chosen: act_rank,
					peer_dpd:         act_dpd,
					peer_ms_nt5:      act_nt5,
					peer_openpgp:     act_pgp,
					useful:           act_useful,
					match_entry:      pend_found_q ? 7'(pend_hit_q) : 7'd0,
					matched:          pend_found_q
				};
			end else if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_op)
							vidm_pkg::OP_LOAD_PATTERN: begin
							end
							vidm_pkg::OP_LOAD_DESC: begin
								if (32'(in_item.entry_index) < vidm_pkg::TABLE_ENTRIES) begin
									desc_vld_q[vidm_pkg::ENTRY_W'(in_item.entry_index)] <= 1'b1;
								end
							end
							vidm_pkg::OP_PAYLOAD: begin
								cnt_q   <= cnt_next;
								rd_e_q  <= '0;
								issue_q <= 1'b1;
								state_q <= ST_SWEEP;
							end
							vidm_pkg::OP_NEW_MESSAGE: begin
								flag_pgp_q  <= 1'b0;
								flag_nt5_q  <= 1'b0;
								flag_dpd_q  <= 1'b0;
								rank_held_q <= '0;
								cnt_q       <= '0;
							end
							default: begin
							end
						endcase
					end
				end

				ST_SWEEP: begin
					if (sweep_end) begin
						// stop at the first match or after the last entry
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						if (last_q) begin
							pend_found_q <= hit_s1;
							cnt_q        <= '0;
							state_q      <= ST_RESULT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						// issue one entry read per cycle
						vld_s1 <= issue_q;
						if (issue_q) begin
							rd_e_q <= rd_e_q + 1'b1;
							if (rd_e_q == LAST_ENTRY) begin
								issue_q <= 1'b0;
							end
						end
					end
				end

				ST_RESULT: begin
					// hold until the output register is free
					if (res_go) begin
						flag_pgp_q  <= act_pgp;
						flag_nt5_q  <= act_nt5;
						flag_dpd_q  <= act_dpd;
						rank_held_q <= act_rank;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Payload count never runs past its saturation value
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= vidm_pkg::CNT_W'(vidm_pkg::PATTERN_BYTES + 1))
		else $error("payload count beyond saturation");

	// Entry evaluation only happens inside a sweep
	a_s1_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || issue_q) |-> (state_q == ST_SWEEP))
		else $error("sweep pipeline active outside sweep");

	// The payload count is restarted before a result is delivered
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> (cnt_q == '0))
		else $error("payload state not restarted at end of payload");

	// A result leaves the result state with a valid output
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && (!out_vld_q || m_axis_tready)) |=>
		(out_vld_q && state_q == ST_IDLE))
		else $error("result not delivered");
`endif

endmodule

`default_nettype wire
